// File: rtl/msw_pkg.sv
`timescale 1ns / 1ps
package msw_pkg;

  localparam int PHASE_BITS_DEF  = 24;
  localparam int TABLE_BITS_DEF  = 10;
  localparam int SAMPLE_BITS_DEF = 16;

  localparam int STEP_W     = 23;
  localparam int AMP_W      = 15;
  localparam int REQ_W      = 3;
  localparam int MODE_W     = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 23;

  localparam logic ACT_TICK = 1'b0;
  localparam logic ACT_CMD  = 1'b1;

  typedef enum logic [MODE_W-1:0] {
    MODE_OFF    = 2'd0,
    MODE_SINE   = 2'd1,
    MODE_SQUARE = 2'd2,
    MODE_PULSE  = 2'd3
  } mode_e;

  typedef enum logic [REQ_W-1:0] {
    REQ_OFF    = 3'd0,
    REQ_SINE   = 3'd1,
    REQ_TOGGLE = 3'd2,
    REQ_SQUARE = 3'd3,
    REQ_PULSE  = 3'd4
  } req_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PHASE_STEP = 2'd0,
    CFG_AMPLITUDE  = 2'd1
  } cfg_idx_e;

  typedef struct packed {
    logic  is_tick;
    mode_e mode;
  } item_ctrl_t;

  // odd polynomial for sin(pi/2 x), Q30 coefficients
  localparam longint unsigned C1 = 64'd1686629713;
  localparam longint unsigned C3 = 64'd693598670;
  localparam longint unsigned C5 = 64'd85569305;
  localparam longint unsigned C7 = 64'd5026995;
  localparam longint unsigned C9 = 64'd172272;
  localparam longint unsigned Q30_ONE = 64'd1 << 30;

  // rom entry: bit sample_bits-1 is the sign, the bits below the magnitude
  function automatic longint unsigned sine_entry(int k, int table_bits, int sample_bits);
    longint unsigned quarter, quad, offs, r, x, x2, s, full, mag, neg;
    quarter = 64'd1 << (table_bits - 2);
    quad    = longint'(k) >> (table_bits - 2);
    offs    = longint'(k) & (quarter - 64'd1);
    r       = quad[0] ? (quarter - offs) : offs;
    x       = r << (30 - (table_bits - 2));
    x2      = (x * x) >> 30;
    s       = C9;
    s       = C7 - ((x2 * s) >> 30);
    s       = C5 - ((x2 * s) >> 30);
    s       = C3 - ((x2 * s) >> 30);
    s       = C1 - ((x2 * s) >> 30);
    s       = (x * s) >> 30;
    if (s > Q30_ONE) begin
      s = Q30_ONE;
    end
    full = (64'd1 << (sample_bits - 1)) - 64'd1;
    mag  = (s * full + (64'd1 << 29)) >> 30;
    if (mag > full) begin
      mag = full;
    end
    neg = ((quad >= 64'd2) && (mag != 64'd0)) ? 64'd1 : 64'd0;
    return (neg << (sample_bits - 1)) | mag;
  endfunction

endpackage

// File: rtl/msw_if.sv
`timescale 1ns / 1ps
interface msw_in_if;
  logic                     valid;
  logic                     ready;
  logic                     action;
  logic [msw_pkg::REQ_W-1:0] mode_request;

  modport source (output valid, action, mode_request, input ready);
  modport sink   (input valid, action, mode_request, output ready);
endinterface

interface msw_out_if #(
  parameter int SAMPLE_BITS = msw_pkg::SAMPLE_BITS_DEF
);
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_BITS-1:0] sample;
  logic                       driving;
  logic [msw_pkg::MODE_W-1:0] mode_now;
  logic                       is_tick;

  modport source (output valid, sample, driving, mode_now, is_tick, input ready);
  modport sink   (input valid, sample, driving, mode_now, is_tick, output ready);
endinterface

interface msw_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [msw_pkg::CFG_IDX_W-1:0]  index;
  logic [msw_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// File: rtl/msw_ctrl.sv
`timescale 1ns / 1ps
module msw_ctrl #(
  parameter int PHASE_BITS = msw_pkg::PHASE_BITS_DEF,
  parameter int TABLE_BITS = msw_pkg::TABLE_BITS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_fire_i,
  input  logic [msw_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [msw_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic                           in_fire_i,
  input  logic                           action_i,
  input  logic [msw_pkg::REQ_W-1:0]      mode_request_i,
  output logic [TABLE_BITS-1:0]          rom_addr_o,
  output msw_pkg::item_ctrl_t            ctrl_o,
  output logic [msw_pkg::AMP_W-1:0]      amplitude_o
);

  localparam int SUM_W = ((PHASE_BITS > msw_pkg::STEP_W) ? PHASE_BITS : msw_pkg::STEP_W) + 1;

  logic [msw_pkg::STEP_W-1:0] step_q;
  logic [msw_pkg::AMP_W-1:0]  amp_q;
  logic [PHASE_BITS-1:0]      phase_q, phase_d;
  logic                       turn_q, turn_d;
  msw_pkg::mode_e             mode_q, mode_d;
  logic [SUM_W-1:0]           sum;
  logic                       pulse_end;

  // config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= '0;
      amp_q  <= '0;
    end else if (cfg_fire_i) begin
      case (cfg_index_i)
        msw_pkg::CFG_PHASE_STEP: step_q <= cfg_data_i[msw_pkg::STEP_W-1:0];
        msw_pkg::CFG_AMPLITUDE:  amp_q  <= cfg_data_i[msw_pkg::AMP_W-1:0];
        default: ;
      endcase
    end
  end

  assign sum       = SUM_W'(phase_q) + SUM_W'(step_q);
  assign pulse_end = (mode_q == msw_pkg::MODE_PULSE) && turn_q && (phase_q != '0);

  always_comb begin
    phase_d = phase_q;
    turn_d  = turn_q;
    mode_d  = mode_q;
    if (action_i == msw_pkg::ACT_CMD) begin
      phase_d = '0;
      turn_d  = 1'b0;
      case (mode_request_i)
        msw_pkg::REQ_OFF:    mode_d = msw_pkg::MODE_OFF;
        msw_pkg::REQ_SINE:   mode_d = msw_pkg::MODE_SINE;
        msw_pkg::REQ_TOGGLE: begin
          mode_d = (mode_q == msw_pkg::MODE_OFF) ? msw_pkg::MODE_SINE : msw_pkg::MODE_OFF;
        end
        msw_pkg::REQ_SQUARE: mode_d = msw_pkg::MODE_SQUARE;
        msw_pkg::REQ_PULSE:  mode_d = msw_pkg::MODE_PULSE;
        default:             mode_d = mode_q;
      endcase
    end else begin
      if (pulse_end) begin
        mode_d = msw_pkg::MODE_OFF;
      end
      phase_d = sum[PHASE_BITS-1:0];
      if (|sum[SUM_W-1:PHASE_BITS]) begin
        turn_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= '0;
      turn_q  <= 1'b0;
      mode_q  <= msw_pkg::MODE_OFF;
    end else if (in_fire_i) begin
      phase_q <= phase_d;
      turn_q  <= turn_d;
      mode_q  <= mode_d;
    end
  end

  // rom sees the phase before this word advances it
  assign rom_addr_o     = phase_q[PHASE_BITS-1 -: TABLE_BITS];
  assign ctrl_o.is_tick = (action_i == msw_pkg::ACT_TICK);
  assign ctrl_o.mode    = mode_d;
  assign amplitude_o    = amp_q;

  a_cmd_clears_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire_i && (action_i == msw_pkg::ACT_CMD) |=> (phase_q == '0) && !turn_q)
    else $error("phase not cleared by command");

  a_cmd_off: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire_i && (action_i == msw_pkg::ACT_CMD) && (mode_request_i == msw_pkg::REQ_OFF)
    |=> (mode_q == msw_pkg::MODE_OFF))
    else $error("off command left generator running");

  a_idle_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_fire_i |=> $stable(phase_q) && $stable(mode_q))
    else $error("state moved without an accepted word");

endmodule

// File: rtl/msw_rom.sv
`timescale 1ns / 1ps
module msw_rom #(
  parameter int TABLE_BITS  = msw_pkg::TABLE_BITS_DEF,
  parameter int SAMPLE_BITS = msw_pkg::SAMPLE_BITS_DEF
) (
  input  logic                   clk_i,
  input  logic                   rd_en_i,
  input  logic [TABLE_BITS-1:0]  addr_i,
  output logic [SAMPLE_BITS-1:0] rd_data_o
);

  localparam int DEPTH = 2 ** TABLE_BITS;

  typedef logic [SAMPLE_BITS-1:0] rom_t [DEPTH];

  function automatic rom_t build_rom();
    rom_t            r;
    longint unsigned e;
    int              k;
    for (k = 0; k < DEPTH; k++) begin
      e    = msw_pkg::sine_entry(k, TABLE_BITS, SAMPLE_BITS);
      r[k] = e[SAMPLE_BITS-1:0];
    end
    return r;
  endfunction

  localparam rom_t ROM = build_rom();

  logic [SAMPLE_BITS-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= ROM[addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// File: rtl/msw_shape.sv
`timescale 1ns / 1ps
module msw_shape #(
  parameter int SAMPLE_BITS = msw_pkg::SAMPLE_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_fire_i,
  input  msw_pkg::item_ctrl_t           ctrl_i,
  input  logic [msw_pkg::AMP_W-1:0]     amplitude_i,
  input  logic [SAMPLE_BITS-1:0]        rom_data_i,
  input  logic                          out_ready_i,
  output logic                          in_ready_o,
  output logic                          out_valid_o,
  output logic signed [SAMPLE_BITS-1:0] sample_o,
  output logic                          driving_o,
  output logic [msw_pkg::MODE_W-1:0]    mode_now_o,
  output logic                          is_tick_o
);

  localparam int MAG_W  = SAMPLE_BITS - 1;
  localparam int PROD_W = msw_pkg::AMP_W + MAG_W;
  localparam logic [PROD_W-1:0] ROUND = PROD_W'(1) << (msw_pkg::AMP_W - 1);
  localparam logic [MAG_W-1:0]  FULL  = '1;

  logic                   s1_valid_q, out_valid_q;
  msw_pkg::item_ctrl_t    s1_ctrl_q, out_ctrl_q;
  logic [SAMPLE_BITS-1:0] sample_q, sample_d;
  logic                   s1_adv;
  logic [PROD_W-1:0]      sine_prod, sq_prod;
  logic [MAG_W-1:0]       rom_mag, sine_mag, sq_mag, mag;
  logic                   rom_neg, sine_neg, neg, positive;

  assign s1_adv     = !out_valid_q || out_ready_i;
  assign in_ready_o = !s1_valid_q || s1_adv;

  assign rom_neg  = rom_data_i[SAMPLE_BITS-1];
  assign rom_mag  = rom_data_i[MAG_W-1:0];
  assign sine_prod = PROD_W'(amplitude_i) * PROD_W'(rom_mag) + ROUND;
  assign sq_prod   = PROD_W'(amplitude_i) * PROD_W'(FULL) + ROUND;
  assign sine_mag  = sine_prod[PROD_W-1:msw_pkg::AMP_W];
  assign sq_mag    = sq_prod[PROD_W-1:msw_pkg::AMP_W];
  assign sine_neg  = rom_neg && (sine_mag != '0);
  assign positive  = (sine_mag != '0) && !sine_neg;

  always_comb begin
    mag = sine_mag;
    neg = sine_neg;
    if (s1_ctrl_q.mode == msw_pkg::MODE_SQUARE) begin
      mag = sq_mag;
      neg = !positive && (sq_mag != '0);
    end
    if (!s1_ctrl_q.is_tick) begin
      sample_d = '0;
    end else if (neg) begin
      sample_d = -{1'b0, mag};
    end else begin
      sample_d = {1'b0, mag};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_ready_o) begin
        s1_valid_q <= in_fire_i;
      end
      if (s1_adv) begin
        out_valid_q <= s1_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire_i) begin
      s1_ctrl_q <= ctrl_i;
    end
    if (s1_adv && s1_valid_q) begin
      sample_q   <= sample_d;
      out_ctrl_q <= s1_ctrl_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign sample_o    = sample_q;
  assign driving_o   = (out_ctrl_q.mode != msw_pkg::MODE_OFF);
  assign mode_now_o  = out_ctrl_q.mode;
  assign is_tick_o   = out_ctrl_q.is_tick;

  a_cmd_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_ctrl_q.is_tick |-> (sample_q == '0))
    else $error("command word carries a nonzero sample");

  a_no_min: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (sample_q != {1'b1, {MAG_W{1'b0}}}))
    else $error("sample outside symmetric range");

  a_s1_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && !s1_adv |=> s1_valid_q && $stable(s1_ctrl_q))
    else $error("stage one word lost under stall");

endmodule

// File: rtl/mode_switched_waveform_generator.sv
`timescale 1ns / 1ps
// Phase-accumulator sine / square / single-pulse generator.
// Channels: in_i takes words of {action, mode_request}; a tick word (action 0)
// produces one sample and advances the phase by phase_step, a command word
// (action 1) clears the phase and sets the mode. out_o returns one word per
// input word: sample, driving, mode_now and is_tick. cfg_i writes
// phase_step (index 0) and amplitude (index 1); other indexes are dropped.
// cfg_i is always ready; write it only while no word is in flight.
// Pipeline: the sine rom read register captures when a word is accepted, and
// the output register then takes the shaped sample from the stage behind it,
// so each result passes both registers before it is valid on out_o.
// Throughput: one word per cycle while out_o.ready is high, set by the phase
// and mode update feeding the rom address.
// Reset: phase, mode (off), phase_step and amplitude all clear; both
// pipeline stages empty.
// Stall: the output register holds while out_o.ready is low; a second word
// still enters the stage behind it, after which in_i.ready drops until
// the output is taken.
module mode_switched_waveform_generator #(
  parameter int PHASE_BITS  = msw_pkg::PHASE_BITS_DEF,
  parameter int TABLE_BITS  = msw_pkg::TABLE_BITS_DEF,
  parameter int SAMPLE_BITS = msw_pkg::SAMPLE_BITS_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  msw_in_if.sink     in_i,
  msw_out_if.source  out_o,
  msw_cfg_if.sink    cfg_i
);

  logic                          in_fire;
  logic                          in_ready;
  logic [TABLE_BITS-1:0]         rom_addr;
  logic [SAMPLE_BITS-1:0]        rom_data;
  logic [msw_pkg::AMP_W-1:0]     amplitude;
  msw_pkg::item_ctrl_t           item_ctrl;

  assign cfg_i.ready = 1'b1;
  assign in_i.ready  = in_ready;
  assign in_fire     = in_i.valid && in_ready;

  msw_ctrl #(
    .PHASE_BITS (PHASE_BITS),
    .TABLE_BITS (TABLE_BITS)
  ) u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_fire_i     (cfg_i.valid),
    .cfg_index_i    (cfg_i.index),
    .cfg_data_i     (cfg_i.data),
    .in_fire_i      (in_fire),
    .action_i       (in_i.action),
    .mode_request_i (in_i.mode_request),
    .rom_addr_o     (rom_addr),
    .ctrl_o         (item_ctrl),
    .amplitude_o    (amplitude)
  );

  msw_rom #(
    .TABLE_BITS  (TABLE_BITS),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_rom (
    .clk_i     (clk_i),
    .rd_en_i   (in_fire),
    .addr_i    (rom_addr),
    .rd_data_o (rom_data)
  );

  msw_shape #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_shape (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_fire_i   (in_fire),
    .ctrl_i      (item_ctrl),
    .amplitude_i (amplitude),
    .rom_data_i  (rom_data),
    .out_ready_i (out_o.ready),
    .in_ready_o  (in_ready),
    .out_valid_o (out_o.valid),
    .sample_o    (out_o.sample),
    .driving_o   (out_o.driving),
    .mode_now_o  (out_o.mode_now),
    .is_tick_o   (out_o.is_tick)
  );

endmodule
